[hdl/mpsm_pkg.sv]
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants for the multi-pattern string matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int CNT_W         = NODE_W + 1;
    localparam int ALPHABET_SIZE = 26;
    localparam int SYM_W         = 5;
    localparam int MAX_WORD_LEN  = 32;
    localparam int LEN_W         = 6;
    localparam int WORD_W        = 8;
    localparam int POS_W         = 16;
    localparam int STATUS_W      = 3;
    localparam int RES_LIMIT     = 32;
    localparam int CHILD_AW      = NODE_W + SYM_W;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_END    = 2'd1;
    localparam logic [1:0] CMD_BUILD  = 2'd2;
    localparam logic [1:0] CMD_MATCH  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 3'd4;

    typedef struct packed {
        logic [1:0]        command;
        logic [SYM_W-1:0]  letter;
        logic [WORD_W-1:0] word_id;
        logic              start_of_text;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic [WORD_W-1:0]   matched_word;
        logic [LEN_W-1:0]    match_length;
        logic [POS_W-1:0]    text_position;
        logic                last;
    } result_t;

endpackage

[hdl/multi_pattern_string_matcher.sv]
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Aho-Corasick matcher: trie load, breadth-first link build, letter matching.
// ----------------------------------------------------------------------------
// After reset the block clears the root row of the child table with busy
// high. One sequencer and single-port table reads with registered data set
// all timing. Insert reads the current node's child slot and depth; an
// existing child is taken, else a new node is made and its child row is
// cleared one entry a cycle. End word marks the current node with the word
// and returns to the root. Build pops each node from the queue, scans its
// letter slots and, for each child found, sets its suffix link (following
// suffix-link hops below the first level) and dictionary link and queues
// it. Match follows suffix-link hops to the landing node, then walks its
// dictionary chain; a match before build returns the not-built status.
// Results of one beat come on consecutive cycles. busy is high from the
// accepting edge until the last result is registered; the receiver cannot
// stall, so each result is on the ports for one cycle with done high.
module multi_pattern_string_matcher
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  mpsm_pkg::item_t   item,
    output logic              busy,
    output logic              done,
    output mpsm_pkg::result_t result
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_INS0  = 5'd2;
    localparam logic [4:0] S_INS1  = 5'd3;
    localparam logic [4:0] S_ROW   = 5'd4;
    localparam logic [4:0] S_END   = 5'd5;
    localparam logic [4:0] S_B0    = 5'd6;
    localparam logic [4:0] S_BPOP  = 5'd7;
    localparam logic [4:0] S_BU    = 5'd8;
    localparam logic [4:0] S_BU2   = 5'd9;
    localparam logic [4:0] S_BKRD  = 5'd10;
    localparam logic [4:0] S_BKCHK = 5'd11;
    localparam logic [4:0] S_BSRD  = 5'd12;
    localparam logic [4:0] S_BSCHK = 5'd13;
    localparam logic [4:0] S_BSNX  = 5'd14;
    localparam logic [4:0] S_BSET  = 5'd15;
    localparam logic [4:0] S_BSET2 = 5'd16;
    localparam logic [4:0] S_M0    = 5'd17;
    localparam logic [4:0] S_MRD   = 5'd18;
    localparam logic [4:0] S_MCHK  = 5'd19;
    localparam logic [4:0] S_MSNX  = 5'd20;
    localparam logic [4:0] S_MHIT  = 5'd21;
    localparam logic [4:0] S_MH2   = 5'd22;

    localparam int NW = mpsm_pkg::NODE_W;
    localparam int SW = mpsm_pkg::SYM_W;
    localparam int WMEM_W = mpsm_pkg::WORD_W + 1;

    // tables
    logic [NW-1:0] child_mem [2**mpsm_pkg::CHILD_AW];
    logic [NW-1:0] suffix_mem [mpsm_pkg::MAX_NODES];
    logic [NW-1:0] dict_mem [mpsm_pkg::MAX_NODES];
    logic [WMEM_W-1:0] word_mem [mpsm_pkg::MAX_NODES];
    logic [mpsm_pkg::LEN_W-1:0] depth_mem [mpsm_pkg::MAX_NODES];
    logic [NW-1:0] queue_mem [mpsm_pkg::MAX_NODES];

    logic                          child_we;
    logic [mpsm_pkg::CHILD_AW-1:0] child_waddr, child_raddr;
    logic [NW-1:0]                 child_wdata, child_q;
    logic                          suffix_we;
    logic [NW-1:0]                 suffix_waddr, suffix_raddr, suffix_wdata, suffix_q;
    logic                          dict_we;
    logic [NW-1:0]                 dict_waddr, dict_raddr, dict_wdata, dict_q;
    logic                          word_we;
    logic [NW-1:0]                 word_waddr, word_raddr;
    logic [WMEM_W-1:0]             word_wdata, word_q;
    logic                          depth_we;
    logic [NW-1:0]                 depth_waddr, depth_raddr;
    logic [mpsm_pkg::LEN_W-1:0]    depth_wdata, depth_q;
    logic                          queue_we;
    logic [NW-1:0]                 queue_waddr, queue_raddr, queue_wdata, queue_q;

    logic [4:0]                 state_reg, state_next;
    mpsm_pkg::item_t            itm_reg, itm_next;
    logic [SW-1:0]              sym_reg, sym_next;
    logic [NW-1:0]              ic_reg, ic_next;
    logic [NW-1:0]              mc_reg, mc_next;
    logic [mpsm_pkg::CNT_W-1:0] nc_reg, nc_next;
    logic [mpsm_pkg::POS_W-1:0] tc_reg, tc_next;
    logic                       built_reg, built_next;
    logic [SW-1:0]              k_reg, k_next;
    logic [mpsm_pkg::CNT_W-1:0] head_reg, head_next;
    logic [mpsm_pkg::CNT_W-1:0] tail_reg, tail_next;
    logic [NW-1:0]              u_reg, u_next;
    logic [NW-1:0]              s_reg, s_next;
    logic [NW-1:0]              v_reg, v_next;
    logic [NW-1:0]              f_reg, f_next;
    logic [NW-1:0]              p_reg, p_next;
    logic [NW-1:0]              su_reg, su_next;
    logic [SW-1:0]              c_reg, c_next;
    logic [SW-1:0]              n_reg, n_next;
    logic [mpsm_pkg::POS_W-1:0] pos_reg, pos_next;
    mpsm_pkg::result_t          res_reg, res_next;
    logic                       done_reg, done_next;

    logic [mpsm_pkg::LEN_W-1:0] depth_cur;
    logic [mpsm_pkg::POS_W-1:0] pos_w;
    logic                       hit_w, last_w;

    function automatic mpsm_pkg::result_t make_res(
        input logic [mpsm_pkg::STATUS_W-1:0] st,
        input logic                          h,
        input logic [mpsm_pkg::WORD_W-1:0]   wid,
        input logic [mpsm_pkg::LEN_W-1:0]    len,
        input logic [mpsm_pkg::POS_W-1:0]    pos,
        input logic                          fin
    );
        mpsm_pkg::result_t r;
        r.status        = st;
        r.hit           = h;
        r.matched_word  = wid;
        r.match_length  = len;
        r.text_position = pos;
        r.last          = fin;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (child_we)
        begin
            child_mem[child_waddr] <= child_wdata;
        end
        child_q <= child_mem[child_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (suffix_we)
        begin
            suffix_mem[suffix_waddr] <= suffix_wdata;
        end
        suffix_q <= suffix_mem[suffix_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dict_we)
        begin
            dict_mem[dict_waddr] <= dict_wdata;
        end
        dict_q <= dict_mem[dict_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_waddr] <= word_wdata;
        end
        word_q <= word_mem[word_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[depth_waddr] <= depth_wdata;
        end
        depth_q <= depth_mem[depth_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
        begin
            queue_mem[queue_waddr] <= queue_wdata;
        end
        queue_q <= queue_mem[queue_raddr];
    end

    // root has depth zero and never carries a word
    assign depth_cur = (ic_reg == '0) ? '0 : depth_q;
    assign pos_w     = itm_reg.start_of_text ? '0 : tc_reg;
    assign hit_w     = (p_reg != '0) && word_q[mpsm_pkg::WORD_W];
    assign last_w    = (dict_q == '0) || (n_reg == SW'(mpsm_pkg::RES_LIMIT - 1));

    always_comb
    begin
        state_next = state_reg;
        itm_next   = itm_reg;
        sym_next   = sym_reg;
        ic_next    = ic_reg;
        mc_next    = mc_reg;
        nc_next    = nc_reg;
        tc_next    = tc_reg;
        built_next = built_reg;
        k_next     = k_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        u_next     = u_reg;
        s_next     = s_reg;
        v_next     = v_reg;
        f_next     = f_reg;
        p_next     = p_reg;
        su_next    = su_reg;
        c_next     = c_reg;
        n_next     = n_reg;
        pos_next   = pos_reg;
        res_next   = res_reg;
        done_next  = 1'b0;

        child_we     = 1'b0;
        child_waddr  = '0;
        child_wdata  = '0;
        child_raddr  = '0;
        suffix_we    = 1'b0;
        suffix_waddr = '0;
        suffix_wdata = '0;
        suffix_raddr = '0;
        dict_we      = 1'b0;
        dict_waddr   = '0;
        dict_wdata   = '0;
        dict_raddr   = '0;
        word_we      = 1'b0;
        word_waddr   = '0;
        word_wdata   = '0;
        word_raddr   = '0;
        depth_we     = 1'b0;
        depth_waddr  = '0;
        depth_wdata  = '0;
        depth_raddr  = '0;
        queue_we     = 1'b0;
        queue_waddr  = '0;
        queue_wdata  = '0;
        queue_raddr  = '0;

        case (state_reg)
            S_CLR:
            begin
                child_we    = 1'b1;
                child_waddr = {{NW{1'b0}}, k_reg};
                k_next      = k_reg + 1'b1;
                if (&k_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    itm_next = item;
                    sym_next = (item.letter >= SW'(mpsm_pkg::ALPHABET_SIZE))
                             ? item.letter - SW'(mpsm_pkg::ALPHABET_SIZE) : item.letter;
                    case (item.command)
                        mpsm_pkg::CMD_INSERT: state_next = S_INS0;
                        mpsm_pkg::CMD_END:    state_next = S_END;
                        mpsm_pkg::CMD_BUILD:  state_next = S_B0;
                        mpsm_pkg::CMD_MATCH:  state_next = S_M0;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_INS0:
            begin
                child_raddr = {ic_reg, sym_reg};
                depth_raddr = ic_reg;
                state_next  = S_INS1;
            end
            S_INS1:
            begin
                if (child_q != '0)
                begin
                    ic_next    = child_q;
                    res_next   = make_res(mpsm_pkg::ST_OK, 1'b0, '0, '0, '0, 1'b1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (depth_cur >= mpsm_pkg::LEN_W'(mpsm_pkg::MAX_WORD_LEN))
                begin
                    res_next   = make_res(mpsm_pkg::ST_TOO_LONG, 1'b0, '0, '0, '0, 1'b1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (nc_reg >= mpsm_pkg::CNT_W'(mpsm_pkg::MAX_NODES))
                begin
                    res_next   = make_res(mpsm_pkg::ST_FULL, 1'b0, '0, '0, '0, 1'b1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    child_we    = 1'b1;
                    child_waddr = {ic_reg, sym_reg};
                    child_wdata = nc_reg[NW-1:0];
                    depth_we    = 1'b1;
                    depth_waddr = nc_reg[NW-1:0];
                    depth_wdata = depth_cur + 1'b1;
                    word_we     = 1'b1;
                    word_waddr  = nc_reg[NW-1:0];
                    word_wdata  = '0;
                    ic_next     = nc_reg[NW-1:0];
                    nc_next     = nc_reg + 1'b1;
                    built_next  = 1'b0;
                    k_next      = '0;
                    state_next  = S_ROW;
                end
            end
            S_ROW:
            begin
                // clear the new node's child row
                child_we    = 1'b1;
                child_waddr = {ic_reg, k_reg};
                k_next      = k_reg + 1'b1;
                if (&k_reg)
                begin
                    res_next   = make_res(mpsm_pkg::ST_OK, 1'b0, '0, '0, '0, 1'b1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_END:
            begin
                if (ic_reg == '0)
                begin
                    res_next = make_res(mpsm_pkg::ST_EMPTY, 1'b0, '0, '0, '0, 1'b1);
                end
                else
                begin
                    word_we    = 1'b1;
                    word_waddr = ic_reg;
                    word_wdata = {1'b1, itm_reg.word_id};
                    built_next = 1'b0;
                    ic_next    = '0;
                    res_next   = make_res(mpsm_pkg::ST_OK, 1'b0, '0, '0, '0, 1'b1);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_B0:
            begin
                suffix_we  = 1'b1;
                dict_we    = 1'b1;
                queue_we   = 1'b1;
                head_next  = '0;
                tail_next  = mpsm_pkg::CNT_W'(1);
                state_next = S_BPOP;
            end
            S_BPOP:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next = 1'b1;
                    mc_next    = '0;
                    tc_next    = '0;
                    res_next   = make_res(mpsm_pkg::ST_OK, 1'b0, '0, '0, '0, 1'b1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    queue_raddr = head_reg[NW-1:0];
                    head_next   = head_reg + 1'b1;
                    state_next  = S_BU;
                end
            end
            S_BU:
            begin
                u_next       = queue_q;
                suffix_raddr = queue_q;
                c_next       = '0;
                state_next   = S_BU2;
            end
            S_BU2:
            begin
                su_next    = suffix_q;
                state_next = S_BKRD;
            end
            S_BKRD:
            begin
                child_raddr = {u_reg, c_reg};
                state_next  = S_BKCHK;
            end
            S_BKCHK:
            begin
                if (child_q == '0)
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = (c_reg == SW'(mpsm_pkg::ALPHABET_SIZE - 1)) ? S_BPOP : S_BKRD;
                end
                else
                begin
                    v_next = child_q;
                    if (u_reg == '0)
                    begin
                        f_next     = '0;
                        state_next = S_BSET;
                    end
                    else
                    begin
                        s_next     = su_reg;
                        state_next = S_BSRD;
                    end
                end
            end
            S_BSRD:
            begin
                child_raddr = {s_reg, c_reg};
                state_next  = S_BSCHK;
            end
            S_BSCHK:
            begin
                if (child_q != '0)
                begin
                    f_next     = child_q;
                    state_next = S_BSET;
                end
                else if (s_reg == '0)
                begin
                    f_next     = '0;
                    state_next = S_BSET;
                end
                else
                begin
                    suffix_raddr = s_reg;
                    state_next   = S_BSNX;
                end
            end
            S_BSNX:
            begin
                s_next     = suffix_q;
                state_next = S_BSRD;
            end
            S_BSET:
            begin
                suffix_we    = 1'b1;
                suffix_waddr = v_reg;
                suffix_wdata = f_reg;
                word_raddr   = f_reg;
                dict_raddr   = f_reg;
                state_next   = S_BSET2;
            end
            S_BSET2:
            begin
                dict_we    = 1'b1;
                dict_waddr = v_reg;
                dict_wdata = ((f_reg != '0) && word_q[mpsm_pkg::WORD_W]) ? f_reg : dict_q;
                if (tail_reg < mpsm_pkg::CNT_W'(mpsm_pkg::MAX_NODES))
                begin
                    queue_we    = 1'b1;
                    queue_waddr = tail_reg[NW-1:0];
                    queue_wdata = v_reg;
                    tail_next   = tail_reg + 1'b1;
                end
                c_next     = c_reg + 1'b1;
                state_next = (c_reg == SW'(mpsm_pkg::ALPHABET_SIZE - 1)) ? S_BPOP : S_BKRD;
            end
            S_M0:
            begin
                if (!built_reg)
                begin
                    res_next   = make_res(mpsm_pkg::ST_NOT_BUILT, 1'b0, '0, '0, '0, 1'b1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    pos_next   = pos_w;
                    tc_next    = (pos_w != '1) ? pos_w + 1'b1 : pos_w;
                    p_next     = itm_reg.start_of_text ? '0 : mc_reg;
                    state_next = S_MRD;
                end
            end
            S_MRD:
            begin
                child_raddr = {p_reg, sym_reg};
                state_next  = S_MCHK;
            end
            S_MCHK:
            begin
                if (child_q != '0)
                begin
                    p_next     = child_q;
                    state_next = S_MHIT;
                end
                else if (p_reg == '0)
                begin
                    state_next = S_MHIT;
                end
                else
                begin
                    suffix_raddr = p_reg;
                    state_next   = S_MSNX;
                end
            end
            S_MSNX:
            begin
                p_next     = suffix_q;
                state_next = S_MRD;
            end
            S_MHIT:
            begin
                mc_next     = p_reg;
                n_next      = '0;
                word_raddr  = p_reg;
                depth_raddr = p_reg;
                dict_raddr  = p_reg;
                state_next  = S_MH2;
            end
            S_MH2:
            begin
                // walk the dictionary chain, one node a cycle
                word_raddr  = dict_q;
                depth_raddr = dict_q;
                dict_raddr  = dict_q;
                p_next      = dict_q;
                if (hit_w)
                begin
                    res_next  = make_res(mpsm_pkg::ST_OK, 1'b1,
                                         word_q[mpsm_pkg::WORD_W-1:0], depth_q, pos_reg, last_w);
                    done_next = 1'b1;
                    n_next    = n_reg + 1'b1;
                    if (last_w)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (dict_q == '0)
                begin
                    res_next   = make_res(mpsm_pkg::ST_OK, 1'b0, '0, '0, pos_reg, 1'b1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            itm_reg   <= '0;
            sym_reg   <= '0;
            ic_reg    <= '0;
            mc_reg    <= '0;
            nc_reg    <= mpsm_pkg::CNT_W'(1);
            tc_reg    <= '0;
            built_reg <= 1'b0;
            k_reg     <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            u_reg     <= '0;
            s_reg     <= '0;
            v_reg     <= '0;
            f_reg     <= '0;
            p_reg     <= '0;
            su_reg    <= '0;
            c_reg     <= '0;
            n_reg     <= '0;
            pos_reg   <= '0;
            res_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            itm_reg   <= itm_next;
            sym_reg   <= sym_next;
            ic_reg    <= ic_next;
            mc_reg    <= mc_next;
            nc_reg    <= nc_next;
            tc_reg    <= tc_next;
            built_reg <= built_next;
            k_reg     <= k_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            u_reg     <= u_next;
            s_reg     <= s_next;
            v_reg     <= v_next;
            f_reg     <= f_next;
            p_reg     <= p_next;
            su_reg    <= su_next;
            c_reg     <= c_next;
            n_reg     <= n_next;
            pos_reg   <= pos_next;
            res_reg   <= res_next;
            done_reg  <= done_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.hit |-> result.status == mpsm_pkg::ST_OK)
        else $error("hit reported with error status");

    a_chain_back2back: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last |=> done && result.hit)
        else $error("gap inside a result burst");

    a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nc_reg <= mpsm_pkg::CNT_W'(mpsm_pkg::MAX_NODES))
        else $error("node count overflow");

endmodule
